@@ design/inlp_pkg.sv @@
// ----------------------------------------------------------------------------
// inlp_pkg
// Shared types, codes and character helpers for the numeric literal parser.
// ----------------------------------------------------------------------------
package inlp_pkg;

    localparam int CHAR_W             = 7;
    localparam int NOTE_W             = 2;
    localparam int BASE_W             = 2;
    localparam int DIGIT_W            = 5;
    localparam int OUT_VALUE_W        = 16;
    localparam int DEFAULT_VALUE_BITS = 16;

    // Notation codes carried with each character.
    localparam logic [NOTE_W-1:0] NOTATION_INTEL = 2'd0;
    localparam logic [NOTE_W-1:0] NOTATION_HEX   = 2'd1;
    localparam logic [NOTE_W-1:0] NOTATION_BIN   = 2'd2;

    // Reported base codes.
    localparam logic [BASE_W-1:0] BASE_BIN = 2'd0;
    localparam logic [BASE_W-1:0] BASE_OCT = 2'd1;
    localparam logic [BASE_W-1:0] BASE_DEC = 2'd2;
    localparam logic [BASE_W-1:0] BASE_HEX = 2'd3;

    // Suffix letters, upper case.
    localparam logic [CHAR_W-1:0] CH_H = 7'h48;
    localparam logic [CHAR_W-1:0] CH_D = 7'h44;
    localparam logic [CHAR_W-1:0] CH_O = 7'h4F;
    localparam logic [CHAR_W-1:0] CH_Q = 7'h51;
    localparam logic [CHAR_W-1:0] CH_B = 7'h42;

    localparam logic [CHAR_W-1:0] CH_0     = 7'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 7'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 7'h46;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 7'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP = 7'h20;

    // Digit code meaning "not 0-9 or A-F".
    localparam logic [DIGIT_W-1:0] DIGIT_BAD = 5'd16;

    typedef struct packed {
        logic over_bin;
        logic over_oct;
        logic over_dec;
        logic non_digit;
    } t_flags;

    function automatic logic [CHAR_W-1:0] to_upper7(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        u = c;
        if (c >= CH_LO_A && c <= CH_LO_Z) begin
            u = c - CASE_GAP;
        end
        return u;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] u);
        logic [DIGIT_W-1:0] d;
        logic [CHAR_W-1:0]  diff;
        d    = DIGIT_BAD;
        diff = '0;
        if (u >= CH_0 && u <= CH_9) begin
            diff = u - CH_0;
            d    = diff[DIGIT_W-1:0];
        end else if (u >= CH_UP_A && u <= CH_UP_F) begin
            diff = u - CH_UP_A;
            d    = diff[DIGIT_W-1:0] + 5'd10;
        end
        return d;
    endfunction

endpackage

@@ design/inlp_fold.sv @@
// ----------------------------------------------------------------------------
// inlp_fold
// Folds one upper-case character into the four running accumulators and the
// error flags. Purely combinational; multiplies are constant shifts and adds.
// ----------------------------------------------------------------------------
module inlp_fold #(
    parameter int VALUE_BITS = inlp_pkg::DEFAULT_VALUE_BITS
) (
    input  logic [VALUE_BITS-1:0]      i_acc_bin,
    input  logic [VALUE_BITS-1:0]      i_acc_oct,
    input  logic [VALUE_BITS-1:0]      i_acc_dec,
    input  logic [VALUE_BITS-1:0]      i_acc_hex,
    input  inlp_pkg::t_flags           i_flags,
    input  logic [inlp_pkg::CHAR_W-1:0] i_char,
    output logic [VALUE_BITS-1:0]      o_acc_bin,
    output logic [VALUE_BITS-1:0]      o_acc_oct,
    output logic [VALUE_BITS-1:0]      o_acc_dec,
    output logic [VALUE_BITS-1:0]      o_acc_hex,
    output inlp_pkg::t_flags           o_flags
);
    import inlp_pkg::*;

    logic [DIGIT_W-1:0]    digit;
    logic                  bad;
    logic                  ok_bin;
    logic                  ok_oct;
    logic                  ok_dec;
    logic [VALUE_BITS-1:0] digit_ext;
    logic [VALUE_BITS-1:0] add_bin;
    logic [VALUE_BITS-1:0] add_oct;
    logic [VALUE_BITS-1:0] add_dec;
    logic [VALUE_BITS-1:0] add_hex;

    always_comb begin
        digit     = digit_of(i_char);
        bad       = digit[DIGIT_W-1];
        ok_bin    = digit < 5'd2;
        ok_oct    = digit < 5'd8;
        ok_dec    = digit < 5'd10;
        digit_ext = VALUE_BITS'(digit[DIGIT_W-2:0]);

        // A bad character adds zero everywhere and is not range checked.
        add_bin = ok_bin ? digit_ext : '0;
        add_oct = ok_oct ? digit_ext : '0;
        add_dec = ok_dec ? digit_ext : '0;
        add_hex = bad ? '0 : digit_ext;

        o_acc_bin = (i_acc_bin << 1) + add_bin;
        o_acc_oct = (i_acc_oct << 3) + add_oct;
        o_acc_dec = (i_acc_dec << 3) + (i_acc_dec << 1) + add_dec;
        o_acc_hex = (i_acc_hex << 4) + add_hex;

        o_flags.over_bin  = i_flags.over_bin | (!bad && !ok_bin);
        o_flags.over_oct  = i_flags.over_oct | (!bad && !ok_oct);
        o_flags.over_dec  = i_flags.over_dec | (!bad && !ok_dec);
        o_flags.non_digit = i_flags.non_digit | bad;
    end

endmodule

@@ design/intel_number_literal_parser_core.sv @@
// ----------------------------------------------------------------------------
// intel_number_literal_parser_core
// Parses Intel-style numeric tokens (suffix, hex prefix or binary prefix
// notation) streamed one character per beat and emits one result per token.
// ----------------------------------------------------------------------------
// A token's last character passes through the input register and then the result register before its result beat.
// Throughput: one character per cycle; the only stall is a waiting result
// register when a token ends, so the rate is set by the output handshake.
// Reset (synchronous, active low) empties both pipeline registers and clears
// the accumulators, flags and held character.
// ----------------------------------------------------------------------------
module intel_number_literal_parser_core #(
    parameter int VALUE_BITS = inlp_pkg::DEFAULT_VALUE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Character beats.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [6:0] char_code, [7] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] notation
    input  logic        i_s_tlast,   // is_last
    // Result beats.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] number_value, [16] bad_char,
                                     // [17] digit_too_large, [23:18] zero
    output logic [1:0]  o_m_tuser    // [1:0] base_code
);
    import inlp_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic [NOTE_W-1:0] r_in_note;
    logic              r_in_last;

    // Token state.
    logic [VALUE_BITS-1:0] r_acc_bin, r_acc_oct, r_acc_dec, r_acc_hex;
    t_flags                r_flags;
    logic [CHAR_W-1:0]     r_held_char;
    logic                  r_held_valid;

    // Result register.
    logic                   r_out_valid;
    logic [OUT_VALUE_W-1:0] r_out_value;
    logic [BASE_W-1:0]      r_out_base;
    logic                   r_out_bad;
    logic                   r_out_over;

    logic [VALUE_BITS-1:0] a1_bin, a1_oct, a1_dec, a1_hex;
    logic [VALUE_BITS-1:0] s1_bin, s1_oct, s1_dec, s1_hex;
    logic [VALUE_BITS-1:0] a2_bin, a2_oct, a2_dec, a2_hex;
    logic [VALUE_BITS-1:0] f_bin, f_oct, f_dec, f_hex;
    logic [VALUE_BITS-1:0] sel_acc;
    logic [VALUE_BITS+OUT_VALUE_W-1:0] sel_wide;
    t_flags                a1_flags, s1_flags, a2_flags, f_flags;
    logic [CHAR_W-1:0]     upper;
    logic                  fold_last;
    logic [BASE_W-1:0]     base;
    logic                  sel_over;
    logic                  out_free;
    logic                  proc_fire;
    logic                  in_fire;

    // First fold: the held character from the previous beat.
    inlp_fold #(.VALUE_BITS(VALUE_BITS)) u_fold_held (
        .i_acc_bin (r_acc_bin),
        .i_acc_oct (r_acc_oct),
        .i_acc_dec (r_acc_dec),
        .i_acc_hex (r_acc_hex),
        .i_flags   (r_flags),
        .i_char    (r_held_char),
        .o_acc_bin (a1_bin),
        .o_acc_oct (a1_oct),
        .o_acc_dec (a1_dec),
        .o_acc_hex (a1_hex),
        .o_flags   (a1_flags)
    );

    // Second fold: the last character, when it turns out to be a digit.
    inlp_fold #(.VALUE_BITS(VALUE_BITS)) u_fold_last (
        .i_acc_bin (s1_bin),
        .i_acc_oct (s1_oct),
        .i_acc_dec (s1_dec),
        .i_acc_hex (s1_hex),
        .i_flags   (s1_flags),
        .i_char    (upper),
        .o_acc_bin (a2_bin),
        .o_acc_oct (a2_oct),
        .o_acc_dec (a2_dec),
        .o_acc_hex (a2_hex),
        .o_flags   (a2_flags)
    );

    always_comb begin
        upper  = to_upper7(r_in_char);
        s1_bin = r_held_valid ? a1_bin : r_acc_bin;
        s1_oct = r_held_valid ? a1_oct : r_acc_oct;
        s1_dec = r_held_valid ? a1_dec : r_acc_dec;
        s1_hex = r_held_valid ? a1_hex : r_acc_hex;
        s1_flags = r_held_valid ? a1_flags : r_flags;

        fold_last = 1'b1;
        base      = BASE_DEC;
        case (r_in_note)
            NOTATION_HEX: base = BASE_HEX;
            NOTATION_BIN: base = BASE_BIN;
            default: begin
                // Intel notation: a trailing suffix letter picks the base.
                if (upper == CH_H) begin
                    fold_last = 1'b0;
                    base      = BASE_HEX;
                end else if (upper == CH_D) begin
                    fold_last = 1'b0;
                    base      = BASE_DEC;
                end else if (upper == CH_O || upper == CH_Q) begin
                    fold_last = 1'b0;
                    base      = BASE_OCT;
                end else if (upper == CH_B) begin
                    fold_last = 1'b0;
                    base      = BASE_BIN;
                end
            end
        endcase

        f_bin   = fold_last ? a2_bin : s1_bin;
        f_oct   = fold_last ? a2_oct : s1_oct;
        f_dec   = fold_last ? a2_dec : s1_dec;
        f_hex   = fold_last ? a2_hex : s1_hex;
        f_flags = fold_last ? a2_flags : s1_flags;

        case (base)
            BASE_BIN: begin
                sel_acc  = f_bin;
                sel_over = f_flags.over_bin;
            end
            BASE_OCT: begin
                sel_acc  = f_oct;
                sel_over = f_flags.over_oct;
            end
            BASE_DEC: begin
                sel_acc  = f_dec;
                sel_over = f_flags.over_dec;
            end
            default: begin
                sel_acc  = f_hex;
                sel_over = 1'b0;
            end
        endcase
        sel_wide = {{OUT_VALUE_W{1'b0}}, sel_acc};
    end

    // A non-final character never needs the result register.
    assign out_free   = !r_out_valid || i_m_tready;
    assign proc_fire  = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || proc_fire;
    assign in_fire    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_char <= i_s_tdata[CHAR_W-1:0];
            r_in_note <= i_s_tuser;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_bin    <= '0;
            r_acc_oct    <= '0;
            r_acc_dec    <= '0;
            r_acc_hex    <= '0;
            r_flags      <= '0;
            r_held_char  <= '0;
            r_held_valid <= 1'b0;
        end else if (proc_fire) begin
            if (r_in_last) begin
                r_acc_bin    <= '0;
                r_acc_oct    <= '0;
                r_acc_dec    <= '0;
                r_acc_hex    <= '0;
                r_flags      <= '0;
                r_held_char  <= '0;
                r_held_valid <= 1'b0;
            end else begin
                r_acc_bin    <= s1_bin;
                r_acc_oct    <= s1_oct;
                r_acc_dec    <= s1_dec;
                r_acc_hex    <= s1_hex;
                r_flags      <= s1_flags;
                r_held_char  <= upper;
                r_held_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && r_in_last) begin
            r_out_value <= sel_wide[OUT_VALUE_W-1:0];
            r_out_base  <= base;
            r_out_bad   <= f_flags.non_digit;
            r_out_over  <= sel_over;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_over, r_out_bad, r_out_value};
    assign o_m_tuser  = r_out_base;

endmodule

@@ tb/sv/tb_intel_number_literal_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_intel_number_literal_parser_core
// Drives numeric tokens into the parser one character per beat. An in-bench
// parse model predicts each token's value, base and flags, and every result
// beat is compared against it in order. A short directed table comes first.
// Random tokens follow, mostly well-formed with some noise. The run passes
// through phases of sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_intel_number_literal_parser_core;
    import inlp_pkg::*;

    // Notation code with no meaning of its own; the block treats it as suffix.
    localparam logic [NOTE_W-1:0] NOTATION_SPARE = 2'd3;

    localparam int N_DIRECTED     = 25;
    localparam int PHASE_CHARS    = 155;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 20;

    typedef struct packed {
        logic [15:0]       value;
        logic [BASE_W-1:0] base;
        logic              bad;
        logic              big;
    } t_lit_result;

    localparam t_lit_result NO_RESULT = '0;

    typedef struct packed {
        logic [7:0]        ch;
        logic [NOTE_W-1:0] note;
        logic              last;
        logic              typed;
        t_lit_result       want;
    } t_stim_row;

    // Hand-written expectations stand only where they are obvious.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{"H",   NOTATION_INTEL, 1'b1, 1'b1, '{16'h0000, BASE_HEX, 1'b0, 1'b0}},
        '{"b",   NOTATION_INTEL, 1'b1, 1'b1, '{16'h0000, BASE_BIN, 1'b0, 1'b0}},
        '{"7",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"F",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"f",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"F",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"h",   NOTATION_INTEL, 1'b1, 1'b1, '{16'h7FFF, BASE_HEX, 1'b0, 1'b0}},
        '{"F",   NOTATION_HEX,   1'b0, 1'b0, NO_RESULT},
        '{"F",   NOTATION_HEX,   1'b0, 1'b0, NO_RESULT},
        '{"f",   NOTATION_HEX,   1'b0, 1'b0, NO_RESULT},
        '{"F",   NOTATION_HEX,   1'b1, 1'b1, '{16'hFFFF, BASE_HEX, 1'b0, 1'b0}},
        '{"1",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"9",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"o",   NOTATION_INTEL, 1'b1, 1'b1, '{16'd8, BASE_OCT, 1'b0, 1'b1}},
        '{"1",   NOTATION_BIN,   1'b0, 1'b0, NO_RESULT},
        '{"Z",   NOTATION_BIN,   1'b1, 1'b1, '{16'd2, BASE_BIN, 1'b1, 1'b0}},
        '{"D",   NOTATION_SPARE, 1'b1, 1'b1, '{16'd0, BASE_DEC, 1'b0, 1'b0}},
        '{8'h00, NOTATION_SPARE, 1'b1, 1'b1, '{16'd0, BASE_DEC, 1'b1, 1'b0}},
        '{"1",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"0",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"1",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"0",   NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"B",   NOTATION_INTEL, 1'b1, 1'b0, NO_RESULT},
        '{8'h7F, NOTATION_INTEL, 1'b0, 1'b0, NO_RESULT},
        '{"Q",   NOTATION_INTEL, 1'b1, 1'b1, '{16'd0, BASE_OCT, 1'b1, 1'b0}}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [6:0] char_code, [7] zero
    logic [1:0]  i_s_tuser  = 2'd0;    // [1:0] notation
    logic        i_s_tlast  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;            // [15:0] number_value, [16] bad_char,
                                       // [17] digit_too_large, [23:18] zero
    logic [1:0]  o_m_tuser;            // [1:0] base_code

    intel_number_literal_parser_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Parse model state.
    logic [15:0]       acc_bin, acc_oct, acc_dec, acc_hex;
    logic              over_bin, over_oct, over_dec, nondigit_seen;
    logic [CHAR_W-1:0] held_ch;
    logic              held_ok;

    t_lit_result expected_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int chars_sent     = 0;
    int tokens_sent    = 0;
    int results_seen   = 0;
    int bad_seen       = 0;
    int big_seen       = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] u);
        if (u >= CH_0 && u <= CH_9) begin
            return DIGIT_W'(u - CH_0);
        end
        if (u >= CH_UP_A && u <= CH_UP_F) begin
            return DIGIT_W'(u - CH_UP_A) + 5'd10;
        end
        return DIGIT_BAD;
    endfunction

    // A digit at or above the radix, or a bad character, adds nothing.
    function automatic logic [15:0] shift_in(input logic [15:0] acc,
                                             input logic [DIGIT_W-1:0] radix,
                                             input logic [DIGIT_W-1:0] d);
        logic [15:0] add;
        add = (d < radix) ? 16'(d) : 16'd0;
        return acc * 16'(radix) + add;
    endfunction

    task automatic clear_parse();
        acc_bin = '0;
        acc_oct = '0;
        acc_dec = '0;
        acc_hex = '0;
        over_bin = 1'b0;
        over_oct = 1'b0;
        over_dec = 1'b0;
        nondigit_seen = 1'b0;
        held_ch = '0;
        held_ok = 1'b0;
    endtask

    task automatic fold_char(input logic [CHAR_W-1:0] u);
        logic [DIGIT_W-1:0] d;
        d = digit_value(u);
        if (d == DIGIT_BAD) begin
            nondigit_seen = 1'b1;
        end else begin
            if (d >= 5'd2)  over_bin = 1'b1;
            if (d >= 5'd8)  over_oct = 1'b1;
            if (d >= 5'd10) over_dec = 1'b1;
        end
        acc_bin = shift_in(acc_bin, 5'd2, d);
        acc_oct = shift_in(acc_oct, 5'd8, d);
        acc_dec = shift_in(acc_dec, 5'd10, d);
        acc_hex = shift_in(acc_hex, 5'd16, d);
    endtask

    // The previous character is folded only when the next one arrives, so that
    // the final one can still be taken as a suffix letter.
    task automatic predict_char(input logic [CHAR_W-1:0] ch, input logic [NOTE_W-1:0] note,
                                input logic last, output bit has_res,
                                output t_lit_result res);
        logic [CHAR_W-1:0] u;
        logic [BASE_W-1:0] base;
        u = ch;
        if (u >= CH_LO_A && u <= CH_LO_Z) u = u - CASE_GAP;
        has_res = 1'b0;
        res = NO_RESULT;
        if (held_ok) fold_char(held_ch);
        held_ch = u;
        held_ok = 1'b1;
        if (last) begin
            if (note == NOTATION_HEX) begin
                fold_char(u);
                base = BASE_HEX;
            end else if (note == NOTATION_BIN) begin
                fold_char(u);
                base = BASE_BIN;
            end else if (u == CH_H) begin
                base = BASE_HEX;
            end else if (u == CH_D) begin
                base = BASE_DEC;
            end else if (u == CH_O || u == CH_Q) begin
                base = BASE_OCT;
            end else if (u == CH_B) begin
                base = BASE_BIN;
            end else begin
                fold_char(u);
                base = BASE_DEC;
            end
            case (base)
                BASE_BIN: begin
                    res.value = acc_bin;
                    res.big   = over_bin;
                end
                BASE_OCT: begin
                    res.value = acc_oct;
                    res.big   = over_oct;
                end
                BASE_DEC: begin
                    res.value = acc_dec;
                    res.big   = over_dec;
                end
                default: begin
                    res.value = acc_hex;
                    res.big   = 1'b0;
                end
            endcase
            res.base = base;
            res.bad  = nondigit_seen;
            has_res  = 1'b1;
            clear_parse();
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_char(input logic [7:0] ch, input logic [NOTE_W-1:0] note,
                             input logic last, input logic typed,
                             input t_lit_result typed_res);
        bit          has_res;
        t_lit_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {1'b0, ch[6:0]};
        i_s_tuser  = note;
        i_s_tlast  = last;
        do @(posedge i_clk); while (!o_s_tready);
        chars_sent++;
        predict_char(ch[6:0], note, last, has_res, res);
        if (has_res) begin
            expected_q.push_back(typed ? typed_res : res);
            tokens_sent++;
        end
        @(negedge i_clk);
    endtask

    // Mostly well-formed tokens in one of the six forms, some pure noise.
    task automatic send_token();
        logic [7:0]         chars[$];
        logic [NOTE_W-1:0]  note;
        logic [DIGIT_W-1:0] radix;
        logic [DIGIT_W-1:0] d;
        logic [7:0]         c;
        int                 form;
        int                 ndig;
        int                 r;
        bit                 suffix;
        note   = NOTATION_INTEL;
        radix  = 5'd10;
        suffix = 1'b1;
        if ($urandom_range(0, 99) < 8) begin
            note = NOTE_W'($urandom_range(0, 3));
            ndig = $urandom_range(1, 6);
            repeat (ndig) chars.push_back(8'($urandom_range(0, 127)));
        end else begin
            form = $urandom_range(0, 5);
            case (form)
                0: radix = 5'd16;
                1: begin
                    radix  = 5'd10;
                    suffix = ($urandom_range(0, 2) != 0);
                end
                2: radix = 5'd8;
                3: radix = 5'd2;
                4: begin
                    radix  = 5'd16;
                    note   = NOTATION_HEX;
                    suffix = 1'b0;
                end
                default: begin
                    radix  = 5'd2;
                    note   = NOTATION_BIN;
                    suffix = 1'b0;
                end
            endcase
            if (form < 4 && $urandom_range(0, 99) < 5) note = NOTATION_SPARE;
            ndig = $urandom_range(0, 8);
            if (!suffix && ndig == 0) ndig = 1;
            for (int i = 0; i < ndig; i++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    c = 8'($urandom_range(0, 127));
                end else begin
                    d = (r < 14) ? DIGIT_W'($urandom_range(0, 15))
                                 : DIGIT_W'($urandom_range(0, radix - 1));
                    c = (d < 5'd10) ? 8'("0") + 8'(d) : 8'("A") + 8'(d) - 8'd10;
                    if (d >= 5'd10 && $urandom_range(0, 1) == 1) c = c | 8'(CASE_GAP);
                end
                chars.push_back(c);
            end
            if (suffix) begin
                case (form)
                    0: c = {1'b0, CH_H};
                    1: c = {1'b0, CH_D};
                    2: c = ($urandom_range(0, 1) == 1) ? {1'b0, CH_O} : {1'b0, CH_Q};
                    default: c = {1'b0, CH_B};
                endcase
                if ($urandom_range(0, 1) == 1) c = c | 8'(CASE_GAP);
                chars.push_back(c);
            end
        end
        foreach (chars[i]) begin
            send_char(chars[i], note, i == chars.size() - 1, 1'b0, NO_RESULT);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready = 1'b0;
            hold_left--;
        end else if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES - 1;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_lit_result want;
        t_lit_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.value = o_m_tdata[15:0];
            got.bad   = o_m_tdata[16];
            got.big   = o_m_tdata[17];
            got.base  = o_m_tuser;
            results_seen++;
            if (got.bad) bad_seen++;
            if (got.big) big_seen++;
            if (expected_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected:", $time,
                             " value %h base %0d bad %b big %b",
                             got.value, got.base, got.bad, got.big);
            end else begin
                want = expected_q.pop_front();
                if (got.value != want.value || got.base != want.base ||
                    got.bad != want.bad || got.big != want.big) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: result mismatch,", $time,
                                 " expected value %h base %0d bad %b big %b,",
                                 want.value, want.base, want.bad, want.big,
                                 " got value %h base %0d bad %b big %b",
                                 got.value, got.base, got.bad, got.big);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_q.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int send_pcts [5];
        int recv_pcts [5];
        send_pcts = '{0, 54, 0, 10, 0};
        recv_pcts = '{0, 0, 54, 10, 0};
        clear_parse();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            send_char(directed_rows[k].ch, directed_rows[k].note, directed_rows[k].last,
                      directed_rows[k].typed, directed_rows[k].want);
        end

        // The last phase runs the sender flat out into a long output hold-off.
        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            if (ph == 4) hold_asked++;
            while (chars_sent < N_DIRECTED + PHASE_CHARS * (ph + 1)) send_token();
        end
        i_s_tvalid = 1'b0;
        recv_stall_pct = 0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters in %0d tokens across gap, stall and hold-off phases.",
                 chars_sent, tokens_sent);
        $display("Checked %0d results: %0d flagged a bad character, %0d a digit too large.",
                 results_seen, bad_seen, big_seen);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
